// ===== rtl/blt_pkg.sv =====
// package for the basic language tokenizer: modes, token kinds, error codes,
// character constants, keyword table and the idle-scan decode function
// no dependencies
`timescale 1ns / 1ps

package blt_pkg;

  localparam int KW_CHARS   = 8;
  localparam int KW_NUM     = 11;
  localparam int LEN_W      = 16;
  localparam int KIND_W     = 5;
  localparam int ERR_W      = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_EQ      = 4'd2,
    M_LT      = 4'd3,
    M_GT      = 4'd4,
    M_BANG    = 4'd5,
    M_STRING  = 4'd6,
    M_INT     = 4'd7,
    M_DOT     = 4'd8,
    M_FRAC    = 4'd9,
    M_WORD    = 4'd10
  } mode_t;

  localparam logic [KIND_W-1:0] K_EOF      = 5'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE  = 5'd1;
  localparam logic [KIND_W-1:0] K_NUMBER   = 5'd2;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd3;
  localparam logic [KIND_W-1:0] K_STRING   = 5'd4;
  localparam logic [KIND_W-1:0] K_KEYWORD0 = 5'd5;
  localparam logic [KIND_W-1:0] K_EQ       = 5'd16;
  localparam logic [KIND_W-1:0] K_PLUS     = 5'd17;
  localparam logic [KIND_W-1:0] K_MINUS    = 5'd18;
  localparam logic [KIND_W-1:0] K_STAR     = 5'd19;
  localparam logic [KIND_W-1:0] K_SLASH    = 5'd20;
  localparam logic [KIND_W-1:0] K_EQEQ     = 5'd21;
  localparam logic [KIND_W-1:0] K_NOTEQ    = 5'd22;
  localparam logic [KIND_W-1:0] K_LT       = 5'd23;
  localparam logic [KIND_W-1:0] K_LTEQ     = 5'd24;
  localparam logic [KIND_W-1:0] K_GT       = 5'd25;
  localparam logic [KIND_W-1:0] K_GTEQ     = 5'd26;

  localparam logic [ERR_W-1:0] E_OK      = 3'd0;
  localparam logic [ERR_W-1:0] E_BANG    = 3'd1;
  localparam logic [ERR_W-1:0] E_STRCHAR = 3'd2;
  localparam logic [ERR_W-1:0] E_NODIGIT = 3'd3;
  localparam logic [ERR_W-1:0] E_UNKNOWN = 3'd4;
  localparam logic [ERR_W-1:0] E_UNTERM  = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // last character of the word sits in the low byte
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
    64'("LABEL"), 64'("GOTO"), 64'("PRINT"), 64'("INPUT"), 64'("LET"),
    64'("IF"), 64'("THEN"), 64'("ENDIF"), 64'("WHILE"), 64'("REPEAT"),
    64'("ENDWHILE")
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd4, 4'd5, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd6, 4'd8
  };

  typedef struct packed {
    logic [KIND_W-1:0] tok_kind;
    logic [15:0]       tok_start;
    logic [LEN_W-1:0]  tok_length;
    logic [ERR_W-1:0]  error_code;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    mode_t             mode;
    logic              open;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [KIND_W-1:0] keyword_kind(
    input logic [8*KW_CHARS-1:0] prefix,
    input logic [3:0]            count
  );
    logic [KIND_W-1:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (count == KW_LEN[k] && prefix == KW_TEXT[k]) begin
        kind = K_KEYWORD0 + KIND_W'(k);
      end
    end
    return kind;
  endfunction

  // decode of one character seen with no token open
  function automatic idle_t scan_idle(input logic [7:0] c);
    idle_t r;
    r.mode = M_IDLE;
    r.open = 1'b0;
    r.emit = 1'b0;
    r.kind = K_EOF;
    r.err  = E_OK;
    unique case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_HASH:  r.mode = M_COMMENT;
      CH_LF:    begin r.emit = 1'b1; r.kind = K_NEWLINE; end
      CH_PLUS:  begin r.emit = 1'b1; r.kind = K_PLUS; end
      CH_MINUS: begin r.emit = 1'b1; r.kind = K_MINUS; end
      CH_STAR:  begin r.emit = 1'b1; r.kind = K_STAR; end
      CH_SLASH: begin r.emit = 1'b1; r.kind = K_SLASH; end
      CH_EQUAL: begin r.mode = M_EQ; r.open = 1'b1; end
      CH_LESS:  begin r.mode = M_LT; r.open = 1'b1; end
      CH_GREAT: begin r.mode = M_GT; r.open = 1'b1; end
      CH_BANG:  begin r.mode = M_BANG; r.open = 1'b1; end
      CH_QUOTE: begin r.mode = M_STRING; r.open = 1'b1; end
      default: begin
        if (is_digit(c)) begin
          r.mode = M_INT;
          r.open = 1'b1;
        end else if (is_alpha(c)) begin
          r.mode = M_WORD;
          r.open = 1'b1;
        end else begin
          r.emit = 1'b1;
          r.err  = E_UNKNOWN;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/blt_char_if.sv =====
// character channel: valid/ready handshake with one source byte or end marker
// no dependencies
`timescale 1ns / 1ps

interface blt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

// ===== rtl/blt_token_if.sv =====
// token channel: valid/ready handshake with one token or error result
// no dependencies
`timescale 1ns / 1ps

interface blt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  tok_kind;
  logic [15:0] tok_start;
  logic [15:0] tok_length;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output tok_kind, output tok_start, output tok_length,
                  output error_code, output last_of_run, input ready);
  modport sink (input valid, input tok_kind, input tok_start, input tok_length,
                input error_code, input last_of_run, output ready);
endinterface

// ===== rtl/basic_language_tokenizer.sv =====
// streaming tokenizer top level: scan state, per-character decode, result queue
// depends on blt_pkg, blt_char_if, blt_token_if
`timescale 1ns / 1ps

//  channel  | dir | payload                                              | transfer
//  ---------+-----+------------------------------------------------------+-----------------
//  chars    | in  | ch, end_of_input                                     | valid && ready
//  tokens   | out | tok_kind, tok_start, tok_length, error_code, last_of_run | valid && ready
//
//  one character is taken per cycle while chars.ready is high; its zero, one or two
//  tokens are written at that transfer into a four-entry result queue and offered from
//  the next cycle, one per cycle; chars.ready is high while at most two tokens wait, so
//  a stall on tokens stops input once three are queued
//  reset (rst, synchronous) empties the queue and sets the scanner idle at position 0

module basic_language_tokenizer
  import blt_pkg::*;
#(
  parameter int POS_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  blt_char_if.sink    chars,
  blt_token_if.source tokens
);

  mode_t                   mode, mode_next;
  logic [POS_WIDTH-1:0]    char_position, char_position_next;
  logic [POS_WIDTH-1:0]    token_origin, token_origin_next;
  logic [8*KW_CHARS-1:0]   word_prefix, word_prefix_next;
  logic [3:0]              word_count, word_count_next;
  logic [LEN_W-1:0]        run_length, run_length_next;

  result_t                 fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr, rd_ptr;
  logic [FIFO_AW:0]        q_count;

  result_t                 res0, res1;
  logic [1:0]              n_res;
  logic                    in_xfer, out_xfer;
  idle_t                   ir;
  logic [LEN_W-1:0]        run_grown;

  assign in_xfer   = chars.valid && chars.ready;
  assign out_xfer  = tokens.valid && tokens.ready;
  assign chars.ready = (q_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign run_grown = (run_length == '1) ? run_length : run_length + LEN_W'(1);
  assign ir        = scan_idle(chars.ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      char_position <= '0;
      token_origin  <= '0;
      word_prefix   <= '0;
      word_count    <= '0;
      run_length    <= '0;
    end else if (in_xfer) begin
      mode          <= mode_next;
      char_position <= char_position_next;
      token_origin  <= token_origin_next;
      word_prefix   <= word_prefix_next;
      word_count    <= word_count_next;
      run_length    <= run_length_next;
    end
  end

  always_comb begin
    logic    do_idle;
    result_t t;
    do_idle            = 1'b0;
    mode_next          = mode;
    char_position_next = char_position + POS_WIDTH'(1);
    token_origin_next  = token_origin;
    word_prefix_next   = word_prefix;
    word_count_next    = word_count;
    run_length_next    = run_length;
    n_res              = 2'd0;
    res0               = '0;
    res1               = '0;
    t                  = '0;
    t.tok_start        = 16'(token_origin);
    t.tok_length       = run_length;

    if (chars.end_of_input) begin
      mode_next          = M_IDLE;
      char_position_next = '0;
      n_res              = 2'd1;
      unique case (mode)
        M_EQ:     begin t.tok_kind = K_EQ; t.tok_length = LEN_W'(1); end
        M_LT:     begin t.tok_kind = K_LT; t.tok_length = LEN_W'(1); end
        M_GT:     begin t.tok_kind = K_GT; t.tok_length = LEN_W'(1); end
        M_INT, M_FRAC: t.tok_kind = K_NUMBER;
        M_WORD:   t.tok_kind = keyword_kind(word_prefix, word_count);
        M_BANG:   t.error_code = E_BANG;
        M_DOT:    t.error_code = E_NODIGIT;
        M_STRING: t.error_code = E_UNTERM;
        M_IDLE, M_COMMENT: n_res = 2'd0;
        default:  n_res = 2'd0;
      endcase
      res0 = t;
      if (mode != M_BANG && mode != M_DOT && mode != M_STRING) begin
        t            = '0;
        t.tok_kind   = K_EOF;
        t.tok_start  = 16'(char_position);
        if (n_res == 2'd0) res0 = t;
        else res1 = t;
        n_res = n_res + 2'd1;
      end
    end else begin
      unique case (mode)
        M_COMMENT: do_idle = (chars.ch == CH_LF);
        M_EQ, M_LT, M_GT: begin
          mode_next = M_IDLE;
          n_res     = 2'd1;
          if (chars.ch == CH_EQUAL) begin
            t.tok_kind   = (mode == M_EQ) ? K_EQEQ : ((mode == M_LT) ? K_LTEQ : K_GTEQ);
            t.tok_length = LEN_W'(2);
          end else begin
            t.tok_kind   = (mode == M_EQ) ? K_EQ : ((mode == M_LT) ? K_LT : K_GT);
            t.tok_length = LEN_W'(1);
            do_idle      = 1'b1;
          end
        end
        M_BANG: begin
          mode_next = M_IDLE;
          n_res     = 2'd1;
          if (chars.ch == CH_EQUAL) begin
            t.tok_kind   = K_NOTEQ;
            t.tok_length = LEN_W'(2);
          end else begin
            t.error_code = E_BANG;
          end
        end
        M_STRING: begin
          if (chars.ch == CH_QUOTE) begin
            mode_next    = M_IDLE;
            n_res        = 2'd1;
            t.tok_kind   = K_STRING;
            t.tok_length = run_grown;
          end else if (chars.ch == CH_LF || chars.ch == CH_CR || chars.ch == CH_TAB ||
                       chars.ch == CH_BSLASH || chars.ch == CH_PCT) begin
            mode_next    = M_IDLE;
            n_res        = 2'd1;
            t.error_code = E_STRCHAR;
          end else begin
            run_length_next = run_grown;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(chars.ch)) begin
            run_length_next = run_grown;
          end else if (mode == M_INT && chars.ch == CH_DOT) begin
            run_length_next = run_grown;
            mode_next       = M_DOT;
          end else begin
            n_res      = 2'd1;
            t.tok_kind = K_NUMBER;
            do_idle    = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(chars.ch)) begin
            run_length_next = run_grown;
            mode_next       = M_FRAC;
          end else begin
            mode_next    = M_IDLE;
            n_res        = 2'd1;
            t.error_code = E_NODIGIT;
          end
        end
        M_WORD: begin
          if (is_alpha(chars.ch) || is_digit(chars.ch)) begin
            run_length_next = run_grown;
            if (word_count < 4'(KW_CHARS)) begin
              word_prefix_next = {word_prefix[8*KW_CHARS-9:0], chars.ch};
              word_count_next  = word_count + 4'd1;
            end else begin
              word_count_next = 4'(KW_CHARS + 1);
            end
          end else begin
            n_res      = 2'd1;
            t.tok_kind = keyword_kind(word_prefix, word_count);
            do_idle    = 1'b1;
          end
        end
        M_IDLE:  do_idle = 1'b1;
        default: do_idle = 1'b1;
      endcase
      res0 = t;

      if (do_idle) begin
        mode_next = ir.mode;
        if (ir.open) begin
          token_origin_next = char_position;
          run_length_next   = LEN_W'(1);
        end
        if (ir.mode == M_WORD) begin
          word_prefix_next = {{(8*KW_CHARS-8){1'b0}}, chars.ch};
          word_count_next  = 4'd1;
        end
        if (ir.emit) begin
          t            = '0;
          t.tok_kind   = ir.kind;
          t.tok_start  = 16'(char_position);
          t.tok_length = LEN_W'(1);
          t.error_code = ir.err;
          if (n_res == 2'd0) res0 = t;
          else res1 = t;
          n_res = n_res + 2'd1;
        end
      end
    end

    if (n_res == 2'd1) res0.last_of_run = 1'b1;
    if (n_res == 2'd2) res1.last_of_run = 1'b1;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      fifo[wr_ptr + FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + FIFO_AW'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      q_count <= q_count + (FIFO_AW+1)'(in_xfer ? n_res : 2'd0)
                         - (FIFO_AW+1)'(out_xfer);
    end
  end

  assign tokens.valid       = (q_count != '0);
  assign tokens.tok_kind    = fifo[rd_ptr].tok_kind;
  assign tokens.tok_start   = fifo[rd_ptr].tok_start;
  assign tokens.tok_length  = fifo[rd_ptr].tok_length;
  assign tokens.error_code  = fifo[rd_ptr].error_code;
  assign tokens.last_of_run = fifo[rd_ptr].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_eof_rewind: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && chars.end_of_input) |=> (char_position == '0 && mode == M_IDLE))
    else $error("end marker did not rewind scanner");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !chars.end_of_input) |=>
      (char_position == $past(char_position) + POS_WIDTH'(1)))
    else $error("position did not advance");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    word_count <= 4'(KW_CHARS + 1))
    else $error("word count out of range");

endmodule
